// File: hdl/pfld_pkg.sv
`timescale 1ns / 1ps
package pfld_pkg;

	localparam int MODE_W  = 2;
	localparam int COORD_W = 8;
	localparam int INDEX_W = 10;
	localparam int BYTE_W  = 8;

	typedef enum logic [MODE_W-1:0] {
		MODE_FILL  = 2'd0,
		MODE_PIXEL = 2'd1,
		MODE_LINE  = 2'd2,
		MODE_READ  = 2'd3
	} mode_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;    // latch the request fields, rewind the sweep counter
		logic rd_sel;    // memory read address from the read index
		logic clr_run;   // write fill byte at sweep counter, advance
		logic pix_wr;    // write back the modified byte of the current pixel
		logic step;      // advance the line walk by one pixel
		logic out_load;  // load the response register
	} ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic clr_last;
		logic at_end;
		logic out_busy;
	} sts_t;

endpackage

// File: hdl/pfld_cmd_if.sv
`timescale 1ns / 1ps
interface pfld_cmd_if;
	logic                              valid;
	logic                              ready;
	logic [pfld_pkg::MODE_W-1:0]       mode;
	logic [pfld_pkg::COORD_W-1:0]      x_start;
	logic [pfld_pkg::COORD_W-1:0]      y_start;
	logic [pfld_pkg::COORD_W-1:0]      x_end;
	logic [pfld_pkg::COORD_W-1:0]      y_end;
	logic                              ink;
	logic [pfld_pkg::INDEX_W-1:0]      read_index;

	modport source (
		output valid, mode, x_start, y_start, x_end, y_end, ink, read_index,
		input  ready
	);
	modport sink (
		input  valid, mode, x_start, y_start, x_end, y_end, ink, read_index,
		output ready
	);
endinterface

// File: hdl/pfld_rsp_if.sv
`timescale 1ns / 1ps
interface pfld_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [pfld_pkg::BYTE_W-1:0]  read_byte;

	modport source (
		output valid, read_byte,
		input  ready
	);
	modport sink (
		input  valid, read_byte,
		output ready
	);
endinterface

// File: hdl/pfld_ctrl.sv
`timescale 1ns / 1ps
module pfld_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [pfld_pkg::MODE_W-1:0] in_mode,
	output logic                        in_ready,
	output pfld_pkg::ctl_t              ctl,
	input  pfld_pkg::sts_t              sts
);
	import pfld_pkg::*;

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_PLOT  = 6'b000100,
		S_WRITE = 6'b001000,
		S_RD    = 6'b010000,
		S_ROUT  = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_nx;

	always_comb begin
		state_nx = state_q;
		ctl      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				ctl.clr_run = 1'b1;
				if (sts.clr_last) begin
					state_nx = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.accept = 1'b1;
					unique case (mode_t'(in_mode)) inside
						MODE_FILL:             state_nx = S_CLEAR;
						MODE_PIXEL, MODE_LINE: state_nx = S_PLOT;
						MODE_READ:             state_nx = S_RD;
						default:               state_nx = S_IDLE;
					endcase
				end
			end
			// byte of the current pixel is read here, written back in S_WRITE
			S_PLOT: begin
				state_nx = S_WRITE;
			end
			S_WRITE: begin
				ctl.pix_wr = 1'b1;
				if (sts.at_end) begin
					state_nx = S_IDLE;
				end else begin
					ctl.step = 1'b1;
					state_nx = S_PLOT;
				end
			end
			S_RD: begin
				ctl.rd_sel = 1'b1;
				state_nx   = S_ROUT;
			end
			S_ROUT: begin
				ctl.rd_sel = 1'b1;
				if (!sts.out_busy) begin
					ctl.out_load = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	// reset starts with a zero-fill sweep of the store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

// File: hdl/pfld_datapath.sv
`timescale 1ns / 1ps
module pfld_datapath #(
	parameter int SCREEN_WIDTH  = 128,
	parameter int SCREEN_HEIGHT = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pfld_pkg::ctl_t               ctl,
	output pfld_pkg::sts_t               sts,
	input  logic [pfld_pkg::MODE_W-1:0]  mode,
	input  logic [pfld_pkg::COORD_W-1:0] x_start,
	input  logic [pfld_pkg::COORD_W-1:0] y_start,
	input  logic [pfld_pkg::COORD_W-1:0] x_end,
	input  logic [pfld_pkg::COORD_W-1:0] y_end,
	input  logic                         ink,
	input  logic [pfld_pkg::INDEX_W-1:0] read_index,
	pfld_rsp_if.source                   rsp
);
	import pfld_pkg::*;

	localparam int PAGE_COUNT  = (SCREEN_HEIGHT + 7) / 8;
	localparam int STORE_BYTES = SCREEN_WIDTH * PAGE_COUNT;
	localparam int AW          = $clog2(STORE_BYTES);
	localparam int ERR_W       = COORD_W + 3;
	localparam logic [AW-1:0]      LAST_ADDR  = AW'(STORE_BYTES - 1);
	localparam logic [COORD_W:0]   WIDTH_LIM  = (COORD_W + 1)'(SCREEN_WIDTH);
	localparam logic [COORD_W:0]   HEIGHT_LIM = (COORD_W + 1)'(SCREEN_HEIGHT);

	// request setup
	logic                      line_mode;
	logic [COORD_W-1:0]        xb_in, yb_in, dx_in, dy_in;
	logic signed [ERR_W-1:0]   err_in;

	// line walk registers
	logic [COORD_W-1:0]        xa_q, ya_q, xb_q, yb_q, dx_q, dy_q;
	logic                      sx_q, sy_q, ink_q;
	logic signed [ERR_W-1:0]   err_q;

	// fill sweep and read request
	logic [AW-1:0]             cnt_q;
	logic                      fill_q;
	logic [INDEX_W-1:0]        ridx_q;
	logic                      rok_q;

	// response register
	logic                      out_valid_q;
	logic [BYTE_W-1:0]         out_byte_q;

	// walk step
	logic signed [ERR_W-1:0]   dxs, dys, err_nx;
	logic                      x_go, y_go;
	logic [COORD_W-1:0]        xa_nx, ya_nx;

	// frame store
	logic [BYTE_W-1:0]         mem_q [STORE_BYTES];
	logic [BYTE_W-1:0]         rdata_q;
	logic [AW-1:0]             pix_addr, raddr, waddr;
	logic [BYTE_W-1:0]         mask, wdata;
	logic                      on_screen, we;

	always_comb begin
		line_mode = (mode_t'(mode) == MODE_LINE);
		xb_in     = line_mode ? x_end : x_start;
		yb_in     = line_mode ? y_end : y_start;
		dx_in     = (xb_in > x_start) ? xb_in - x_start : x_start - xb_in;
		dy_in     = (yb_in > y_start) ? yb_in - y_start : y_start - yb_in;
		// half of the major delta, truncated toward zero
		if (dx_in > dy_in) begin
			err_in = $signed(ERR_W'(dx_in[COORD_W-1:1]));
		end else begin
			err_in = -$signed(ERR_W'(dy_in[COORD_W-1:1]));
		end
	end

	always_comb begin
		dxs    = $signed(ERR_W'(dx_q));
		dys    = $signed(ERR_W'(dy_q));
		x_go   = (err_q > -dxs);
		y_go   = (err_q < dys);
		err_nx = err_q - (x_go ? dys : ERR_W'(0)) + (y_go ? dxs : ERR_W'(0));
		xa_nx  = xa_q;
		ya_nx  = ya_q;
		if (x_go) begin
			xa_nx = sx_q ? xa_q + COORD_W'(1) : xa_q - COORD_W'(1);
		end
		if (y_go) begin
			ya_nx = sy_q ? ya_q + COORD_W'(1) : ya_q - COORD_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			xa_q   <= x_start;
			ya_q   <= y_start;
			xb_q   <= xb_in;
			yb_q   <= yb_in;
			dx_q   <= dx_in;
			dy_q   <= dy_in;
			sx_q   <= (x_start < xb_in);
			sy_q   <= (y_start < yb_in);
			err_q  <= err_in;
			ink_q  <= ink;
			ridx_q <= read_index;
			rok_q  <= (int'(read_index) < STORE_BYTES);
		end else if (ctl.step) begin
			xa_q  <= xa_nx;
			ya_q  <= ya_nx;
			err_q <= err_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			fill_q <= 1'b0;
		end else if (ctl.accept) begin
			cnt_q  <= '0;
			fill_q <= ink;
		end else if (ctl.clr_run) begin
			cnt_q <= cnt_q + AW'(1);
		end
	end

	// pixel address: column plus page times width
	always_comb begin
		on_screen = ({1'b0, xa_q} < WIDTH_LIM) && ({1'b0, ya_q} < HEIGHT_LIM);
		pix_addr  = AW'(xa_q) + AW'(int'(ya_q[COORD_W-1:3]) * SCREEN_WIDTH);
		mask      = BYTE_W'(1) << ya_q[2:0];
		raddr     = ctl.rd_sel ? AW'(ridx_q) : pix_addr;
		waddr     = ctl.clr_run ? cnt_q : pix_addr;
		we        = ctl.clr_run || (ctl.pix_wr && on_screen);
		if (ctl.clr_run) begin
			wdata = {BYTE_W{fill_q}};
		end else if (ink_q) begin
			wdata = rdata_q | mask;
		end else begin
			wdata = rdata_q & ~mask;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			out_byte_q <= rok_q ? rdata_q : '0;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.read_byte = out_byte_q;

	assign sts.clr_last = (cnt_q == LAST_ADDR);
	assign sts.at_end   = (xa_q == xb_q) && (ya_q == yb_q);
	assign sts.out_busy = out_valid_q && !rsp.ready;

endmodule

// File: hdl/page_framebuffer_line_drawer_core.sv
`timescale 1ns / 1ps
// channel  dir  handshake      payload
// cmd      in   valid/ready    mode, x_start, y_start, x_end, y_end, ink, read_index
// rsp      out  valid/ready    read_byte (read requests only)
//
// One request at a time. Pixel: the byte is read in S_PLOT and written back in S_WRITE.
// Line: the same read and write back for each pixel. Fill: one byte a cycle over all
// STORE_BYTES bytes. Read: S_RD, then S_ROUT loads the response register, waiting while rsp is stalled.
// After reset the store is zeroed by a sweep over all STORE_BYTES bytes (1024 at the
// default size) during which cmd.ready stays low.
module page_framebuffer_line_drawer_core #(
	parameter int SCREEN_WIDTH  = 128,
	parameter int SCREEN_HEIGHT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	pfld_cmd_if.sink    cmd,
	pfld_rsp_if.source  rsp
);
	import pfld_pkg::*;

	ctl_t ctl;
	sts_t sts;

	pfld_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.valid),
		.in_mode  (cmd.mode),
		.in_ready (cmd.ready),
		.ctl      (ctl),
		.sts      (sts)
	);

	pfld_datapath #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.sts        (sts),
		.mode       (cmd.mode),
		.x_start    (cmd.x_start),
		.y_start    (cmd.y_start),
		.x_end      (cmd.x_end),
		.y_end      (cmd.y_end),
		.ink        (cmd.ink),
		.read_index (cmd.read_index),
		.rsp        (rsp)
	);

endmodule

// File: hdl/pfld_checker.sv
`timescale 1ns / 1ps
module pfld_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         cmd_valid,
	input logic                         cmd_ready,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic [pfld_pkg::BYTE_W-1:0]  rsp_read_byte
);
	import pfld_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_read_byte))
		else $error("response byte changed while stalled");

	// every accepted request makes the block busy and drops cmd_ready
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("request taken while the previous one is in progress");

	// a new response is loaded only from the read path, which returns to idle
	a_rsp_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> cmd_ready && !$past(cmd_ready))
		else $error("response appeared outside a read");

endmodule

bind page_framebuffer_line_drawer_core pfld_checker u_pfld_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cmd_valid     (cmd.valid),
	.cmd_ready     (cmd.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_read_byte (rsp.read_byte)
);
